### hdl/assert_macros.svh
// Assertion macros shared by the mailbox RTL.
// No dependencies; included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

### hdl/tmm_pkg.sv
// Constants and types for the tagged message mailbox.
// No dependencies.
package tmm_pkg;
  localparam int QUEUE_DEPTH = 8;
  localparam int MAX_BYTES   = 32;
  localparam int ID_BITS     = 8;
  localparam int SLOT_W      = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int LEN_W       = $clog2(MAX_BYTES + 1);
  localparam int OFS_W       = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int ADDR_W      = SLOT_W + OFS_W;

  localparam logic [1:0] MODE_SEND = 2'd0;
  localparam logic [1:0] MODE_RXSR = 2'd1;
  localparam logic [1:0] MODE_RXR  = 2'd2;

  localparam logic [2:0] KIND_SENT  = 3'd0;
  localparam logic [2:0] KIND_TRUNC = 3'd1;
  localparam logic [2:0] KIND_FULL  = 3'd2;
  localparam logic [2:0] KIND_BYTE  = 3'd3;
  localparam logic [2:0] KIND_NONE  = 3'd4;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;
endpackage

### hdl/tmm_ram.sv
// Payload byte store, one write and one registered read port.
// Depends on tmm_pkg.
module tmm_ram import tmm_pkg::*; (
  input  logic       clk,
  input  ram_req_t   req,
  output logic [7:0] rdata
);
  logic [7:0] mem [QUEUE_DEPTH*MAX_BYTES];
  always_ff @(posedge clk) begin
    if (req.we) mem[req.waddr] <= req.wdata;
    rdata <= mem[req.raddr];
  end
endmodule

### hdl/tagged_message_mailbox.sv
// Top level of the tagged message mailbox: sequencer, slot tables, output register.
// Depends on tmm_pkg, tmm_ram and assert_macros.svh.
//
// channel | ports                                          | dir
// in      | in_valid/in_ready, mode, ids, byte, last, count | sink
// out     | out_valid/out_ready, kind, out_byte, out_last  | source
//
// Send byte: take, then store; a final byte then waits for its status transfer.
// Receive: take, then scan for a match (tag compare unit steps one queue position per cycle;
// a miss scans all queued positions, at most QUEUE_DEPTH), then per payload byte a read
// through the store's registered read port and an output transfer, then a shift of the
// order table.
// Reset clears queue count, assembly state and order table; stores start undefined.
// Output stalls hold the sequencer; no input is taken while a result waits to be taken.
`include "assert_macros.svh"
module tagged_message_mailbox import tmm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_mode,
  input  logic [7:0] in_from_id,
  input  logic [7:0] in_to_id,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  input  logic [5:0] in_byte_count,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_kind,
  output logic [7:0] out_out_byte,
  output logic       out_out_last
);
  localparam logic [2:0] S_IDLE = 3'd0, S_SEND = 3'd1, S_SCAN = 3'd2,
                         S_RD = 3'd3, S_EMIT = 3'd4, S_SHIFT = 3'd5, S_WAIT = 3'd6;

  logic [2:0] st_r, st_nxt;
  logic [1:0] mode_r;
  logic [ID_BITS-1:0] from_r, to_r;
  logic [7:0] dat_r;
  logic last_r;
  logic [5:0] want_r;

  logic [ID_BITS-1:0] snd_r [QUEUE_DEPTH];
  logic [ID_BITS-1:0] rcv_r [QUEUE_DEPTH];
  logic [LEN_W-1:0]   len_r [QUEUE_DEPTH];
  logic [SLOT_W-1:0]  ord_r [QUEUE_DEPTH];
  logic [CNT_W-1:0]   cnt_r;
  logic [LEN_W-1:0]   alen_r;
  logic               aovf_r;

  logic [SLOT_W-1:0] pos_r;   // scan position, later match position
  logic [LEN_W-1:0]  n_r, i_r;
  logic              ov_r;
  logic [2:0]        kind_r;
  logic [7:0]        byte_r;
  logic              olast_r;

  ram_req_t   req;
  logic [7:0] rdata;
  tmm_ram u_ram (.clk(clk), .req(req), .rdata(rdata));

  logic [SLOT_W-1:0] tail_slot, cur_slot;
  logic full, hit;
  logic [LEN_W:0] want_e, n_calc;
  assign tail_slot = ord_r[cnt_r[SLOT_W-1:0]];
  assign cur_slot  = ord_r[pos_r];
  assign full      = cnt_r >= CNT_W'(QUEUE_DEPTH);
  assign hit = (rcv_r[cur_slot] == to_r) &&
               (mode_r == MODE_RXR || snd_r[cur_slot] == from_r);
  assign in_ready = (st_r == S_IDLE);

  always_comb begin
    want_e = (want_r == 6'd0) ? (LEN_W+1)'(1) : (LEN_W+1)'(want_r);
    n_calc = {1'b0, len_r[cur_slot]};
    if (n_calc > want_e) n_calc = want_e;
    if (n_calc > (LEN_W+1)'(MAX_BYTES)) n_calc = (LEN_W+1)'(MAX_BYTES);
    req.we    = (st_r == S_SEND) && !full && (alen_r < LEN_W'(MAX_BYTES));
    req.waddr = {tail_slot, alen_r[OFS_W-1:0]};
    req.wdata = dat_r;
    req.raddr = {cur_slot, i_r[OFS_W-1:0]};
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: if (in_valid) begin
        if (in_mode == MODE_SEND) st_nxt = S_SEND;
        else if (in_mode == MODE_RXSR || in_mode == MODE_RXR) st_nxt = S_SCAN;
      end
      S_SEND: st_nxt = last_r ? S_WAIT : S_IDLE;
      S_SCAN: begin
        if ({1'b0, pos_r} >= (SLOT_W+1)'(cnt_r)) st_nxt = S_WAIT;
        else if (hit) st_nxt = (n_calc == '0) ? S_WAIT : S_RD;
        else if (pos_r == SLOT_W'(QUEUE_DEPTH-1)) st_nxt = S_WAIT;
      end
      S_RD:    st_nxt = S_EMIT;
      S_EMIT:  if (out_ready) st_nxt = (i_r + 1'b1 == n_r) ? S_SHIFT : S_RD;
      S_SHIFT: st_nxt = S_IDLE;
      S_WAIT:  if (out_ready) st_nxt = ov_r ? S_SHIFT : S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      cnt_r <= '0;
      alen_r <= '0;
      aovf_r <= 1'b0;
      for (int k = 0; k < QUEUE_DEPTH; k++) ord_r[k] <= SLOT_W'(k);
    end else begin
      st_r <= st_nxt;
      case (st_r)
        S_IDLE: if (in_valid) begin
          mode_r <= in_mode;
          from_r <= in_from_id[ID_BITS-1:0];
          to_r   <= in_to_id[ID_BITS-1:0];
          dat_r  <= in_data_byte;
          last_r <= in_last_byte;
          want_r <= in_byte_count;
          pos_r  <= '0;
          i_r    <= '0;
          ov_r   <= 1'b0;
        end
        S_SEND: begin
          if (alen_r < LEN_W'(MAX_BYTES)) begin
            if (!last_r) alen_r <= alen_r + 1'b1;
          end else if (!last_r) aovf_r <= 1'b1;
          if (last_r) begin
            kind_r  <= full ? KIND_FULL :
                       (aovf_r || alen_r >= LEN_W'(MAX_BYTES)) ? KIND_TRUNC : KIND_SENT;
            if (!full) begin
              snd_r[tail_slot] <= from_r;
              rcv_r[tail_slot] <= to_r;
              len_r[tail_slot] <= (alen_r < LEN_W'(MAX_BYTES)) ? alen_r + 1'b1 : alen_r;
              cnt_r <= cnt_r + 1'b1;
            end
            byte_r  <= '0;
            olast_r <= 1'b1;
            alen_r  <= '0;
            aovf_r  <= 1'b0;
          end
        end
        S_SCAN: begin
          if ({1'b0, pos_r} >= (SLOT_W+1)'(cnt_r)) begin
            kind_r <= KIND_NONE; byte_r <= '0; olast_r <= 1'b1;
          end else if (hit) begin
            n_r  <= n_calc[LEN_W-1:0];
            ov_r <= 1'b1;  // entry is removed after output
            if (n_calc == '0) begin
              kind_r <= KIND_NONE; byte_r <= '0; olast_r <= 1'b1;
            end
          end else if (pos_r != SLOT_W'(QUEUE_DEPTH-1)) pos_r <= pos_r + 1'b1;
          else begin
            kind_r <= KIND_NONE; byte_r <= '0; olast_r <= 1'b1;
          end
        end
        // read address stays on the current byte until its transfer
        S_EMIT: if (out_ready) i_r <= i_r + 1'b1;
        S_SHIFT: begin
          for (int k = 0; k < QUEUE_DEPTH-1; k++)
            if (SLOT_W'(k) >= pos_r) ord_r[k] <= ord_r[k+1];
          ord_r[QUEUE_DEPTH-1] <= cur_slot;
          cnt_r <= cnt_r - 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign out_valid    = (st_r == S_WAIT) || (st_r == S_EMIT);
  assign out_kind     = (st_r == S_EMIT) ? KIND_BYTE : kind_r;
  assign out_out_byte = (st_r == S_EMIT) ? rdata : byte_r;
  assign out_out_last = (st_r == S_EMIT) ? (i_r + 1'b1 == n_r) : olast_r;

  `ASSERT_IMPLIES(a_cnt_max, clk, rst_n, 1'b1, cnt_r <= CNT_W'(QUEUE_DEPTH))
  `ASSERT_IMPLIES(a_no_overlap, clk, rst_n, out_valid, !in_ready)
  `ASSERT_NEXT(a_shift_idle, clk, rst_n, st_r == S_SHIFT, in_ready)
endmodule

### bench/tb.sv
// Testbench for tagged_message_mailbox: directed table, then random send/receive traffic.
// Depends on tmm_pkg and the mailbox RTL; results are checked against a local mailbox model.
`timescale 1ns / 1ps
module tb;
  import tmm_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct {
    logic [2:0] kind;
    logic [7:0] data;
    logic       last;
  } mbox_result_t;

  typedef struct {
    logic [1:0] mode;
    logic [7:0] from_id;
    logic [7:0] to_id;
    logic [7:0] data;
    int         nbytes;
    logic [5:0] count;
    bit         typed;
    logic [2:0] kind;
  } stim_row_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] in_mode;
  logic [7:0] in_from_id;
  logic [7:0] in_to_id;
  logic [7:0] in_data_byte;
  logic       in_last_byte;
  logic [5:0] in_byte_count;
  logic       out_valid;
  logic       out_ready;
  logic [2:0] out_kind;
  logic [7:0] out_out_byte;
  logic       out_out_last;

  // local copy of the mailbox state
  logic [7:0]   mb_store [QUEUE_DEPTH][MAX_BYTES];
  logic [7:0]   mb_sender [QUEUE_DEPTH];
  logic [7:0]   mb_receiver [QUEUE_DEPTH];
  int           mb_length [QUEUE_DEPTH];
  int           mb_order [QUEUE_DEPTH];
  int           mb_count;
  int           asm_len;
  bit           asm_ovf;

  mbox_result_t pending_results[$];
  stim_row_t    rows[$];
  int           n_errors;
  int           n_items;
  int           n_results;
  int           n_bytes_out;
  int           n_nomatch;
  int           n_trunc;
  int           n_full;
  bit           quiet;
  bit           took_result;
  int           rx_stall;

  tagged_message_mailbox dut (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("tb: errors");
    $finish;
  end

  task automatic push_result(input logic [2:0] k, input logic [7:0] b, input logic l);
    mbox_result_t r;
    r.kind = k;
    r.data = b;
    r.last = l;
    pending_results.push_back(r);
  endtask

  task automatic mailbox_step(input logic [1:0] m, input logic [7:0] f, input logic [7:0] t,
                              input logic [7:0] d, input logic lb, input logic [5:0] c);
    int  p;
    int  slot;
    int  n;
    bit  full;
    case (m)
      MODE_SEND: begin
        full = mb_count >= QUEUE_DEPTH;
        if (asm_len < MAX_BYTES) begin
          if (!full) mb_store[mb_order[mb_count]][asm_len] = d;
          asm_len++;
        end else begin
          asm_ovf = 1'b1;
        end
        if (lb) begin
          if (full) begin
            push_result(KIND_FULL, 8'd0, 1'b1);
          end else begin
            slot = mb_order[mb_count];
            mb_sender[slot] = f;
            mb_receiver[slot] = t;
            mb_length[slot] = asm_len;
            mb_count++;
            push_result(asm_ovf ? KIND_TRUNC : KIND_SENT, 8'd0, 1'b1);
          end
          asm_len = 0;
          asm_ovf = 1'b0;
        end
      end
      MODE_RXSR, MODE_RXR: begin
        for (p = 0; p < mb_count; p++) begin
          slot = mb_order[p];
          if (mb_receiver[slot] == t && (m == MODE_RXR || mb_sender[slot] == f)) break;
        end
        if (p >= mb_count) begin
          push_result(KIND_NONE, 8'd0, 1'b1);
        end else begin
          n = (c == 0) ? 1 : int'(c);
          if (n > mb_length[slot]) n = mb_length[slot];
          if (n > MAX_BYTES) n = MAX_BYTES;
          for (int i = 0; i < n; i++) push_result(KIND_BYTE, mb_store[slot][i], i == n - 1);
          for (int q = p; q + 1 < QUEUE_DEPTH; q++) mb_order[q] = mb_order[q + 1];
          mb_order[QUEUE_DEPTH - 1] = slot;
          mb_count--;
        end
      end
      default: ;
    endcase
  endtask

  // one transfer on the input channel; typed rows replace the predicted result
  task automatic send_item(input logic [1:0] m, input logic [7:0] f, input logic [7:0] t,
                           input logic [7:0] d, input logic lb, input logic [5:0] c,
                           input bit typed, input logic [2:0] k);
    int gap;
    int before_len;
    gap = quiet ? 0 : $urandom_range(0, 19);
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_mode = m;
    in_from_id = f;
    in_to_id = t;
    in_data_byte = d;
    in_last_byte = lb;
    in_byte_count = c;
    do @(posedge clk); while (!in_ready);
    before_len = pending_results.size();
    mailbox_step(m, f, t, d, lb, c);
    if (typed) begin
      while (pending_results.size() > before_len) void'(pending_results.pop_back());
      push_result(k, 8'd0, 1'b1);
    end
    n_items++;
    if (n_items % 40 == 0) quiet = ~quiet;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic add_row(input logic [1:0] m, input logic [7:0] f, input logic [7:0] t,
                         input logic [7:0] d, input int nb, input logic [5:0] c,
                         input bit typed, input logic [2:0] k);
    stim_row_t r;
    r.mode = m;
    r.from_id = f;
    r.to_id = t;
    r.data = d;
    r.nbytes = nb;
    r.count = c;
    r.typed = typed;
    r.kind = k;
    rows.push_back(r);
  endtask

  // result channel: stall draw per transfer, none during quiet stretches
  always @(negedge clk) begin
    if (took_result) rx_stall = quiet ? 0 : $urandom_range(0, 19);
    if (rx_stall > 0) begin
      out_ready = 1'b0;
      rx_stall--;
    end else begin
      out_ready = rst_n;
    end
  end

  always @(posedge clk) begin
    mbox_result_t e;
    took_result = 1'b0;
    if (rst_n && out_valid && out_ready) begin
      took_result = 1'b1;
      n_results++;
      if (pending_results.size() == 0) begin
        $error("unexpected result kind=%0d byte=%0h last=%0b", out_kind, out_out_byte,
               out_out_last);
        n_errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_kind !== e.kind) begin
          $error("kind: expected %0d, got %0d", e.kind, out_kind);
          n_errors++;
        end
        if (out_out_byte !== e.data) begin
          $error("out_byte: expected %0h, got %0h", e.data, out_out_byte);
          n_errors++;
        end
        if (out_out_last !== e.last) begin
          $error("out_last: expected %0b, got %0b", e.last, out_out_last);
          n_errors++;
        end
        case (e.kind)
          KIND_BYTE:  n_bytes_out++;
          KIND_NONE:  n_nomatch++;
          KIND_TRUNC: n_trunc++;
          KIND_FULL:  n_full++;
          default: ;
        endcase
      end
    end
  end

  initial begin
    logic [7:0] id_pool [4];
    logic [1:0] m;
    logic [7:0] f;
    logic [7:0] t;
    int         msg_left;
    int         msg_len;
    logic [7:0] msg_from;
    logic [7:0] msg_to;
    int         roll;
    int         rnd_items;
    bit         paused;
    logic [5:0] c;

    in_valid = 1'b0;
    in_mode = MODE_SEND;
    in_from_id = 8'd0;
    in_to_id = 8'd0;
    in_data_byte = 8'd0;
    in_last_byte = 1'b0;
    in_byte_count = 6'd1;
    out_ready = 1'b0;
    rst_n = 1'b0;
    took_result = 1'b0;
    rx_stall = 0;
    quiet = 1'b0;
    n_errors = 0;
    n_items = 0;
    n_results = 0;
    n_bytes_out = 0;
    n_nomatch = 0;
    n_trunc = 0;
    n_full = 0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      mb_order[i] = i;
      mb_length[i] = 0;
    end
    mb_count = 0;
    asm_len = 0;
    asm_ovf = 1'b0;

    add_row(MODE_RXR,  8'h00, 8'h00, 8'h00, 1,  6'd1,  1, KIND_NONE);
    add_row(MODE_SEND, 8'h00, 8'hff, 8'hff, 1,  6'd0,  1, KIND_SENT);
    add_row(MODE_SEND, 8'hff, 8'h00, 8'h00, 33, 6'd0,  1, KIND_TRUNC);
    add_row(MODE_RXSR, 8'h00, 8'hff, 8'h00, 1,  6'd0,  0, KIND_NONE);
    add_row(MODE_RXR,  8'h5a, 8'h00, 8'h00, 1,  6'd63, 0, KIND_NONE);
    add_row(MODE_UNUSED, 8'hff, 8'hff, 8'hff, 1, 6'd63, 0, KIND_NONE);
    add_row(MODE_SEND, 8'h01, 8'h02, 8'h55, 5,  6'd0,  0, KIND_NONE);
    add_row(MODE_RXSR, 8'h09, 8'h02, 8'h00, 1,  6'd4,  1, KIND_NONE);
    add_row(MODE_RXR,  8'h00, 8'h02, 8'h00, 1,  6'd3,  0, KIND_NONE);
    for (int i = 0; i < QUEUE_DEPTH; i++)
      add_row(MODE_SEND, 8'(8'h10 + i), 8'h20, 8'(8'h80 + 16 * i), 2, 6'd0, 0, KIND_NONE);
    add_row(MODE_SEND, 8'h33, 8'h20, 8'haa, 3,  6'd0,  1, KIND_FULL);
    add_row(MODE_RXR,  8'h00, 8'h20, 8'h00, 1,  6'd32, 0, KIND_NONE);
    add_row(MODE_RXSR, 8'h17, 8'h20, 8'h00, 1,  6'd1,  0, KIND_NONE);
    add_row(MODE_RXSR, 8'h17, 8'h20, 8'h00, 1,  6'd1,  1, KIND_NONE);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (rows[r]) begin
      if (rows[r].mode == MODE_SEND) begin
        for (int i = 0; i < rows[r].nbytes; i++)
          send_item(MODE_SEND, rows[r].from_id, rows[r].to_id, 8'(rows[r].data + i),
                    i == rows[r].nbytes - 1, 6'($urandom), rows[r].typed && i == rows[r].nbytes - 1,
                    rows[r].kind);
      end else begin
        send_item(rows[r].mode, rows[r].from_id, rows[r].to_id, 8'($urandom), 1'($urandom),
                  rows[r].count, rows[r].typed, rows[r].kind);
      end
    end

    // small id pool so that receives find matches; fresh values each run
    foreach (id_pool[i]) id_pool[i] = 8'($urandom);
    msg_left = 0;
    rnd_items = 0;
    paused = 1'b0;
    while (rnd_items < 80) begin
      if (!paused && rnd_items >= 40) begin
        wait (pending_results.size() == 0);
        paused = 1'b1;
      end
      roll = $urandom_range(0, 99);
      // never receive while a message is being built against a full queue
      if (msg_left > 0 && (roll < 85 || (mb_count >= QUEUE_DEPTH && asm_len > 0))) begin
        msg_left--;
        send_item(MODE_SEND, ($urandom_range(0, 9) == 0) ? 8'($urandom) : msg_from,
                  msg_to, 8'($urandom), msg_left == 0, 6'($urandom), 0, KIND_NONE);
        rnd_items++;
      end else if (msg_left == 0 && roll < 45) begin
        msg_len = ($urandom_range(0, 15) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 6);
        msg_left = msg_len;
        msg_from = ($urandom_range(0, 7) == 0) ? 8'($urandom) : id_pool[$urandom_range(0, 3)];
        msg_to = ($urandom_range(0, 7) == 0) ? 8'($urandom) : id_pool[$urandom_range(0, 3)];
      end else if (!(mb_count >= QUEUE_DEPTH && asm_len > 0)) begin
        roll = $urandom_range(0, 99);
        m = (roll < 45) ? MODE_RXSR : (roll < 92) ? MODE_RXR : MODE_UNUSED;
        f = ($urandom_range(0, 7) == 0) ? 8'($urandom) : id_pool[$urandom_range(0, 3)];
        t = ($urandom_range(0, 7) == 0) ? 8'($urandom) : id_pool[$urandom_range(0, 3)];
        c = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(1, 32));
        send_item(m, f, t, 8'($urandom), 1'($urandom), c, 0, KIND_NONE);
        if (m != MODE_UNUSED) rnd_items++;
      end
    end

    wait (pending_results.size() == 0);
    repeat (200) @(posedge clk);
    $display("tb: %0d items sent, %0d results checked (%0d payload bytes, %0d no-match)",
             n_items, n_results, n_bytes_out, n_nomatch);
    $display("tb: %0d truncated sends, %0d queue-full sends", n_trunc, n_full);
    if (n_errors == 0 && pending_results.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end
endmodule
